@@ rtl/spg_pkg.sv @@
// ----------------------------------------------------------------------------
// spg_pkg: shared types and constants of the Sobol point generator
// Holds the payload structs, the controller/datapath command and status
// structs, the operation codes and the direction table address function.
// ----------------------------------------------------------------------------
package spg_pkg;

  // sizes of the generator
  localparam int MAX_DIMS  = 64;
  localparam int COLUMNS   = 62;
  localparam int DIM_W     = 6;
  localparam int COL_W     = 6;
  localparam int VAL_W     = 62;
  localparam int CFG_W     = 7;
  localparam int DIR_DEPTH = MAX_DIMS * COLUMNS;
  localparam int DIR_AW    = $clog2(DIR_DEPTH);
  localparam int RV_AW     = $clog2(MAX_DIMS);
  // index bits examined per lowest-zero scan cycle
  localparam int SCAN_W    = 4;

  // operation codes, code 3 has no meaning and is ignored
  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_NEXT     = 2'd1,
    OP_AT_INDEX = 2'd2
  } op_e;

  // one request
  typedef struct packed {
    logic [1:0]       operation;
    logic [DIM_W-1:0] dim_index;
    logic [COL_W-1:0] column;
    logic [VAL_W-1:0] direction_value;
    logic [VAL_W-1:0] point_index;
  } spg_in_t;

  // one coordinate
  typedef struct packed {
    logic [VAL_W-1:0] coordinate;
    logic [DIM_W-1:0] out_dim;
    logic [VAL_W-1:0] out_index;
    logic             last_of_point;
    logic             exhausted;
  } spg_out_t;

  // commands from controller to datapath
  typedef struct packed {
    logic             load_we;
    logic             latch;
    logic             use_point;
    logic             rb_issue;
    logic             scan_step;
    logic             em_issue;
    logic [DIM_W-1:0] dim;
    logic [COL_W-1:0] col;
  } spg_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic exh;
    logic scan_done;
  } spg_stat_t;

  // flat address of a direction number
  function automatic logic [DIR_AW-1:0] dir_addr(logic [DIM_W-1:0] dim,
                                                  logic [COL_W-1:0] col);
    dir_addr = DIR_AW'(dim) * DIR_AW'(COLUMNS) + DIR_AW'(col);
  endfunction

endpackage

@@ rtl/sobol_point_generator.sv @@
// ----------------------------------------------------------------------------
// sobol_point_generator: Gray-code Sobol quasirandom point generator
// Emits one 62-bit fraction per active dimension for each requested point.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low. Operation 0
//   loads one direction number into the table and leaves busy low.
//   Operation 1 emits the point at the running index, operation 2
//   first rebuilds all running values for the given index. Code 3 is ignored.
//   Each coordinate is shown for one cycle with result_strobe_o, in
//   dimension order; the receiver cannot hold results off.
//   A next request runs the lowest-zero scan, one nibble of the index a
//   cycle, then 64 dimension steps, one direction table read per cycle.
//   An at-index request first rebuilds from 64 * 62 = 3968 table words,
//   one table word a cycle. An exhausted index skips scan and rebuild.
//   Each coordinate passes the registered table read and the result register.
//   Reset clears the running values (valid bits), the index and sets the
//   dimension count to 1; the direction table is undefined until loaded.
//   The dimension count is written through cfg_we_i while busy is low; the
//   user must keep to this, the block itself does not enforce it.
// ----------------------------------------------------------------------------
module sobol_point_generator (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  spg_pkg::spg_in_t  item_i,
  input  logic              cfg_we_i,
  input  logic [6:0]        cfg_data_i,
  output logic              result_strobe_o,
  output spg_pkg::spg_out_t result_o
);
  import spg_pkg::*;

  spg_cmd_t  cmd;
  spg_stat_t stat;

  // sequencer
  spg_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .op_i     (item_i.operation),
    .column_i (item_i.column),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  // memories and arithmetic
  spg_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .item_i          (item_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .result_strobe_o (result_strobe_o),
    .result_o        (result_o)
  );

endmodule

@@ rtl/spg_ram.sv @@
// ----------------------------------------------------------------------------
// spg_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module spg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/spg_ctrl.sv @@
// ----------------------------------------------------------------------------
// spg_ctrl: sequencer of the Sobol point generator
// Accepts requests, walks the rebuild, lowest-zero scan and emission passes
// and drives the datapath through command signals.
// ----------------------------------------------------------------------------
module spg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic [1:0]        op_i,
  input  logic [5:0]        column_i,
  input  spg_pkg::spg_stat_t stat_i,
  output spg_pkg::spg_cmd_t  cmd_o,
  output logic              busy
);
  import spg_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_REBUILD,
    ST_SCAN,
    ST_EMIT,
    ST_DRAIN1,
    ST_DRAIN2
  } state_e;

  state_e           state_q;
  logic             busy_q;
  logic             at_q;
  logic [DIM_W-1:0] dim_q;
  logic [COL_W-1:0] col_q;
  logic             take;
  logic             is_point_op;

  // request decode
  assign take        = start && !busy_q;
  assign is_point_op = (op_i == OP_NEXT) || (op_i == OP_AT_INDEX);

  // state, counters and busy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
      at_q    <= 1'b0;
      dim_q   <= '0;
      col_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (take && is_point_op) begin
            state_q <= ST_PREP;
            busy_q  <= 1'b1;
            at_q    <= (op_i == OP_AT_INDEX);
          end
        end
        ST_PREP: begin
          dim_q <= '0;
          col_q <= '0;
          priority if (stat_i.exh) begin
            state_q <= ST_EMIT;
          end else if (at_q) begin
            state_q <= ST_REBUILD;
          end else begin
            state_q <= ST_SCAN;
          end
        end
        ST_REBUILD: begin
          if (col_q == COL_W'(COLUMNS - 1)) begin
            col_q <= '0;
            if (dim_q == DIM_W'(MAX_DIMS - 1)) begin
              dim_q   <= '0;
              state_q <= ST_SCAN;
            end else begin
              dim_q <= dim_q + 1'b1;
            end
          end else begin
            col_q <= col_q + 1'b1;
          end
        end
        ST_SCAN: begin
          if (stat_i.scan_done) begin
            dim_q   <= '0;
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (dim_q == DIM_W'(MAX_DIMS - 1)) begin
            state_q <= ST_DRAIN1;
          end else begin
            dim_q <= dim_q + 1'b1;
          end
        end
        ST_DRAIN1: begin
          state_q <= ST_DRAIN2;
        end
        ST_DRAIN2: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
        default: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  // commands to the datapath
  always_comb begin
    cmd_o           = '0;
    cmd_o.load_we   = take && (op_i == OP_LOAD) && (column_i < COL_W'(COLUMNS));
    cmd_o.latch     = take && is_point_op;
    cmd_o.use_point = (op_i == OP_AT_INDEX);
    cmd_o.rb_issue  = (state_q == ST_REBUILD);
    cmd_o.scan_step = (state_q == ST_SCAN);
    cmd_o.em_issue  = (state_q == ST_EMIT);
    cmd_o.dim       = dim_q;
    cmd_o.col       = col_q;
  end

  assign busy = busy_q;

endmodule

@@ rtl/spg_dp.sv @@
// ----------------------------------------------------------------------------
// spg_dp: datapath of the Sobol point generator
// Direction table and running value memories, index registers, the
// lowest-zero scan and the two-stage read/xor/emit pipeline.
// ----------------------------------------------------------------------------
module spg_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [6:0]         cfg_data_i,
  input  spg_pkg::spg_in_t   item_i,
  input  spg_pkg::spg_cmd_t  cmd_i,
  output spg_pkg::spg_stat_t stat_o,
  output logic               result_strobe_o,
  output spg_pkg::spg_out_t  result_o
);
  import spg_pkg::*;

  // trailing ones of a nibble that holds at least one zero
  function automatic logic [1:0] trail_ones(logic [SCAN_W-1:0] v);
    logic [1:0] n;
    priority if (!v[0]) n = 2'd0;
    else if (!v[1]) n = 2'd1;
    else if (!v[2]) n = 2'd2;
    else n = 2'd3;
    return n;
  endfunction

  logic [CFG_W-1:0]    dims_q;
  logic [CFG_W-1:0]    active_n;
  logic [VAL_W-1:0]    idx_q, sr_q, next_idx_q, idx_sel, gray;
  logic [COL_W-1:0]    col_q, rd_col;
  logic                exh_q, exh_sel;
  logic [VAL_W-1:0]    tab_rdata, rv_rdata, rv_eff, rv_wdata, acc_q, acc_d;
  logic                tab_re, rv_we;
  logic [MAX_DIMS-1:0] rv_vld_q;
  logic                s1_valid_q, s1_rb_q, s1_vld_q;
  logic [DIM_W-1:0]    s1_dim_q;
  logic [COL_W-1:0]    s1_col_q;
  logic                emit_now;
  logic                strobe_q;
  spg_out_t            out_q;

  // dimension count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= CFG_W'(1);
    end else if (cfg_we_i) begin
      dims_q <= cfg_data_i;
    end
  end

  always_comb begin
    priority if (dims_q == '0) active_n = CFG_W'(1);
    else if (dims_q > CFG_W'(MAX_DIMS)) active_n = CFG_W'(MAX_DIMS);
    else active_n = dims_q;
  end

  // index of the point being served
  assign idx_sel = cmd_i.use_point ? item_i.point_index : next_idx_q;
  assign exh_sel = &idx_sel;
  assign gray    = idx_q ^ (idx_q >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_idx_q <= '0;
      exh_q      <= 1'b0;
    end else if (cmd_i.latch) begin
      exh_q <= exh_sel;
      if (!exh_sel) begin
        next_idx_q <= idx_sel + 1'b1;
      end
    end
  end

  // lowest zero bit search, one nibble per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      idx_q <= idx_sel;
      sr_q  <= idx_sel;
      col_q <= '0;
    end else if (cmd_i.scan_step) begin
      if (&sr_q[SCAN_W-1:0]) begin
        sr_q  <= sr_q >> SCAN_W;
        col_q <= col_q + COL_W'(SCAN_W);
      end else begin
        col_q <= col_q + COL_W'(trail_ones(sr_q[SCAN_W-1:0]));
      end
    end
  end

  assign stat_o.exh       = exh_q;
  assign stat_o.scan_done = !(&sr_q[SCAN_W-1:0]);

  // direction table
  assign rd_col = cmd_i.rb_issue ? cmd_i.col : col_q;
  assign tab_re = cmd_i.rb_issue || cmd_i.em_issue;

  spg_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DIR_DEPTH)
  ) u_dir_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_we),
    .waddr_i (dir_addr(item_i.dim_index, item_i.column)),
    .wdata_i (item_i.direction_value),
    .re_i    (tab_re),
    .raddr_i (dir_addr(cmd_i.dim, rd_col)),
    .rdata_o (tab_rdata)
  );

  // running values, a clear valid bit reads as zero
  spg_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_DIMS)
  ) u_rv_ram (
    .clk_i   (clk_i),
    .we_i    (rv_we),
    .waddr_i (RV_AW'(s1_dim_q)),
    .wdata_i (rv_wdata),
    .re_i    (cmd_i.em_issue),
    .raddr_i (RV_AW'(cmd_i.dim)),
    .rdata_o (rv_rdata)
  );

  // pipeline stage after the memory read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_rb_q    <= 1'b0;
    end else begin
      s1_valid_q <= tab_re;
      s1_rb_q    <= cmd_i.rb_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_dim_q <= cmd_i.dim;
    s1_col_q <= cmd_i.col;
    s1_vld_q <= rv_vld_q[RV_AW'(cmd_i.dim)];
  end

  // rebuild accumulation over the gray code columns
  assign acc_d = ((s1_col_q == '0) ? '0 : acc_q) ^
                 (gray[s1_col_q] ? tab_rdata : '0);

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_rb_q) begin
      acc_q <= acc_d;
    end
  end

  // running value write back
  assign rv_eff   = s1_vld_q ? rv_rdata : '0;
  assign emit_now = s1_valid_q && !s1_rb_q;

  always_comb begin
    rv_we    = 1'b0;
    rv_wdata = rv_eff ^ tab_rdata;
    if (s1_valid_q && s1_rb_q && (s1_col_q == COL_W'(COLUMNS - 1))) begin
      rv_we    = 1'b1;
      rv_wdata = acc_d;
    end else if (emit_now && !exh_q) begin
      rv_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_vld_q <= '0;
    end else if (rv_we) begin
      rv_vld_q[RV_AW'(s1_dim_q)] <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= emit_now && ({1'b0, s1_dim_q} < active_n);
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_now) begin
      out_q.coordinate    <= exh_q ? '0 : rv_eff;
      out_q.out_dim       <= s1_dim_q;
      out_q.out_index     <= idx_q;
      out_q.last_of_point <= (({1'b0, s1_dim_q} + 1'b1) == active_n);
      out_q.exhausted     <= exh_q;
    end
  end

  assign result_strobe_o = strobe_q;
  assign result_o        = out_q;

endmodule

@@ rtl/spg_checker.sv @@
// ----------------------------------------------------------------------------
// spg_checker: port-level checks of the Sobol point generator
// Watches the request and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module spg_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input spg_pkg::spg_in_t  item_i,
  input logic              cfg_we_i,
  input logic [6:0]        cfg_data_i,
  input logic              result_strobe_o,
  input spg_pkg::spg_out_t result_o
);
  import spg_pkg::*;

  // a point request raises busy in the next cycle
  a_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (item_i.operation == OP_NEXT ||
                        item_i.operation == OP_AT_INDEX)) |=> busy)
    else $error("point request did not raise busy");

  // results only appear while a request is being served
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> busy)
    else $error("result transfer while not busy");

  // coordinates of one point come back to back with rising dimension
  a_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && !result_o.last_of_point) |=>
      (result_strobe_o && result_o.out_dim == DIM_W'($past(result_o.out_dim) + 1'b1)))
    else $error("coordinates of a point not contiguous");

  // nothing follows the last coordinate directly
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && result_o.last_of_point) |=> !result_strobe_o)
    else $error("transfer right after last coordinate");

  // an exhausted point carries zero coordinates
  a_exh_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && result_o.exhausted) |-> (result_o.coordinate == '0))
    else $error("exhausted point with nonzero coordinate");

endmodule

bind sobol_point_generator spg_checker u_spg_checker (.*);
